// ===== rtl/core/mmp_pkg.sv =====
// Shared types and constants of the matrix multiply and power unit.
`default_nettype none
package mmp_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int CFG_W          = 4;
    localparam int PADDR_W        = 4;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2,
        OP_POW    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_INNER  = 2'd1,
        REG_COLS_B = 2'd2,
        REG_NONE   = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        Y_B = 2'd0,
        Y_A = 2'd1,
        Y_P = 2'd2,
        Y_R = 2'd3
    } t_ysel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_WR,
        S_CP_RD,
        S_CP_WR,
        S_NEXT,
        S_EM_RD,
        S_EM_CAP,
        S_EM_HOLD
    } t_state;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
    } t_mac_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/mmp_mem.sv =====
// Synchronous element memory: one write port, one registered read port.
`default_nettype none
module mmp_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/mmp_mac.sv =====
// Multiply-accumulate unit with a registered product and accumulator.
`default_nettype none
module mmp_mac #(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire mmp_pkg::t_mac_ctl     i_ctl,
    input  wire logic [ELEM_WIDTH-1:0] i_x,
    input  wire logic [ELEM_WIDTH-1:0] i_y,
    output logic      [ELEM_WIDTH-1:0] o_acc
);
    import mmp_pkg::*;

    logic [ELEM_WIDTH-1:0] r_prod;
    logic [ELEM_WIDTH-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_x * i_y;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== rtl/core/matrix_multiply_power.sv =====
// Top level of the matrix multiply and matrix power unit.
//
//  channel  | direction | handshake                  | payload
//  input    | in        | i_in_valid / o_in_ready    | op, row, col, value, exponent
//  output   | out       | o_out_valid / i_out_ready  | out_row, out_col, out_value, last, error
//  config   | in        | APB psel/penable/pwrite    | rows_a, inner_dim, cols_b
//
// Loads are written while the unit is idle. A product runs in the single
// multiply-accumulate unit, which reads, multiplies and accumulates each term;
// each sum is written to the scratch memory and then copied back; a power command
// runs one product per set exponent bit and one squaring per bit below the top.
// Each result element is read, captured and held on the output until it is taken.
// Reset is synchronous; stores hold no reset and need no clearing pass.
`default_nettype none
module matrix_multiply_power #(
    parameter int MAX_DIM    = mmp_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mmp_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mmp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_op,
    input  wire logic [2:0]                  i_row,
    input  wire logic [2:0]                  i_col,
    input  wire logic [31:0]                 i_value,
    input  wire logic [31:0]                 i_exponent,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [2:0]                  o_out_row,
    output logic      [2:0]                  o_out_col,
    output logic      [31:0]                 o_out_value,
    output logic                             o_last,
    output logic                             o_error
);
    import mmp_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int W     = ELEM_WIDTH;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * AW'(MAX_DIM) + AW'(c);
    endfunction

    function automatic logic [DW-1:0] f_clamp(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    // configuration
    logic [CFG_W-1:0] r_rows_a, r_inner, r_cols_b;
    t_reg             w_reg;

    assign w_reg  = t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= CFG_W'(8);
            r_inner  <= CFG_W'(8);
            r_cols_b <= CFG_W'(8);
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_ROWS_A: r_rows_a <= pwdata[CFG_W-1:0];
                REG_INNER:  r_inner  <= pwdata[CFG_W-1:0];
                REG_COLS_B: r_cols_b <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ROWS_A: prdata = 32'(r_rows_a);
            REG_INNER:  prdata = 32'(r_inner);
            REG_COLS_B: prdata = 32'(r_cols_b);
            default:    prdata = '0;
        endcase
    end

    // control registers
    t_state          r_state, n_state;
    logic [IW-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DW-1:0]   r_dn, n_dn, r_dm, n_dm, r_dp, n_dp;
    logic [31:0]     r_exp, n_exp;
    logic            r_pow, n_pow;
    logic            r_dst_p, n_dst_p;
    logic            r_ident, n_ident;
    logic            r_pa, n_pa;
    t_ysel           r_ysel, n_ysel;
    logic            r_diag;
    logic            r_o_valid, n_o_valid;
    logic [2:0]      r_o_row, n_o_row, r_o_col, n_o_col;
    logic [31:0]     r_o_value, n_o_value;
    logic            r_o_last, n_o_last, r_o_error, n_o_error;

    // memory signals
    logic            w_ld_ok, w_we_a, w_we_b, w_we_t, w_we_p, w_we_r;
    logic [AW-1:0]   w_ld_addr, w_x_addr, w_y_addr, w_ik_addr, w_r_raddr;
    logic [W-1:0]    w_ld_data;
    logic [W-1:0]    w_ax, w_ay, w_b, w_px, w_py, w_r, w_t, w_acc;
    logic [W-1:0]    w_x, w_y, w_r_eff;
    logic            w_emit;
    t_mac_ctl        w_ctl;
    logic            w_k_end, w_i_end, w_j_end;

    assign w_ld_ok   = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
    assign w_ld_addr = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);
    assign w_ld_data = W'(i_value);
    assign w_x_addr  = f_addr(r_i, r_j);
    assign w_y_addr  = f_addr(r_j, r_k);
    assign w_ik_addr = f_addr(r_i, r_k);
    assign w_emit    = (r_state == S_EM_RD);
    assign w_r_raddr = w_emit ? w_ik_addr : w_y_addr;

    assign w_we_a = (r_state == S_IDLE) && i_in_valid && (t_op'(i_op) == OP_LOAD_A) && w_ld_ok;
    assign w_we_b = (r_state == S_IDLE) && i_in_valid && (t_op'(i_op) == OP_LOAD_B) && w_ld_ok;
    assign w_we_t = (r_state == S_WR);
    assign w_we_p = (r_state == S_CP_WR) && r_dst_p;
    assign w_we_r = (r_state == S_CP_WR) && !r_dst_p;

    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_ax (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_ld_addr), .i_wdata(w_ld_data),
        .i_raddr(w_x_addr), .o_rdata(w_ax)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_ay (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_ld_addr), .i_wdata(w_ld_data),
        .i_raddr(w_y_addr), .o_rdata(w_ay)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(w_ld_addr), .i_wdata(w_ld_data),
        .i_raddr(w_y_addr), .o_rdata(w_b)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_px (
        .i_clk(i_clk), .i_we(w_we_p), .i_waddr(w_ik_addr), .i_wdata(w_t),
        .i_raddr(w_x_addr), .o_rdata(w_px)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_py (
        .i_clk(i_clk), .i_we(w_we_p), .i_waddr(w_ik_addr), .i_wdata(w_t),
        .i_raddr(w_y_addr), .o_rdata(w_py)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_r (
        .i_clk(i_clk), .i_we(w_we_r), .i_waddr(w_ik_addr), .i_wdata(w_t),
        .i_raddr(w_r_raddr), .o_rdata(w_r)
    );
    mmp_mem #(.DEPTH(DEPTH), .WIDTH(W)) u_mem_t (
        .i_clk(i_clk), .i_we(w_we_t), .i_waddr(w_ik_addr), .i_wdata(w_acc),
        .i_raddr(w_ik_addr), .o_rdata(w_t)
    );

    assign w_r_eff = r_ident ? W'(r_diag) : w_r;
    assign w_x     = r_pa ? w_ax : w_px;

    always_comb begin
        case (r_ysel)
            Y_B:     w_y = w_b;
            Y_A:     w_y = w_ay;
            Y_P:     w_y = w_py;
            Y_R:     w_y = w_r_eff;
            default: w_y = w_b;
        endcase
    end

    always_comb begin
        w_ctl.clr = !((r_state == S_RD) || (r_state == S_MUL) || (r_state == S_ACC));
        w_ctl.mul = (r_state == S_MUL);
        w_ctl.acc = (r_state == S_ACC);
    end

    mmp_mac #(.ELEM_WIDTH(W)) u_mac (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_x(w_x), .i_y(w_y), .o_acc(w_acc)
    );

    assign w_j_end = (DW'(r_j) == r_dm - DW'(1));
    assign w_k_end = (DW'(r_k) == r_dp - DW'(1));
    assign w_i_end = (DW'(r_i) == r_dn - DW'(1));

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_dn      = r_dn;
        n_dm      = r_dm;
        n_dp      = r_dp;
        n_exp     = r_exp;
        n_pow     = r_pow;
        n_dst_p   = r_dst_p;
        n_ident   = r_ident;
        n_pa      = r_pa;
        n_ysel    = r_ysel;
        n_o_valid = r_o_valid;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_value = r_o_value;
        n_o_last  = r_o_last;
        n_o_error = r_o_error;
        o_in_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (i_in_valid) begin
                    case (t_op'(i_op))
                        OP_MUL: begin
                            n_dn    = f_clamp(r_rows_a);
                            n_dm    = f_clamp(r_inner);
                            n_dp    = f_clamp(r_cols_b);
                            n_pow   = 1'b0;
                            n_dst_p = 1'b0;
                            n_pa    = 1'b1;
                            n_ysel  = Y_B;
                            n_state = S_RD;
                        end
                        OP_POW: begin
                            if (f_clamp(r_rows_a) != f_clamp(r_inner)) begin
                                n_o_valid = 1'b1;
                                n_o_row   = '0;
                                n_o_col   = '0;
                                n_o_value = '0;
                                n_o_last  = 1'b1;
                                n_o_error = 1'b1;
                                n_state   = S_EM_HOLD;
                            end else begin
                                n_dn    = f_clamp(r_rows_a);
                                n_dm    = f_clamp(r_rows_a);
                                n_dp    = f_clamp(r_rows_a);
                                n_pow   = 1'b1;
                                n_exp   = i_exponent;
                                n_ident = 1'b1;
                                n_pa    = 1'b1;
                                n_state = S_NEXT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:  n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (w_j_end) begin
                    n_state = S_WR;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_RD;
                end
            end
            S_WR: begin
                n_j     = '0;
                n_state = S_RD;
                if (w_k_end) begin
                    n_k = '0;
                    if (w_i_end) begin
                        n_i     = '0;
                        n_state = S_CP_RD;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_CP_RD: n_state = S_CP_WR;
            S_CP_WR: begin
                n_state = S_CP_RD;
                if (w_k_end) begin
                    n_k = '0;
                    if (w_i_end) begin
                        n_i = '0;
                        if (!r_pow) begin
                            n_ident = 1'b0;
                            n_state = S_EM_RD;
                        end else if (!r_dst_p) begin
                            n_ident = 1'b0;
                            if (r_exp == 32'd1) begin
                                n_state = S_EM_RD;
                            end else begin
                                n_dst_p = 1'b1;
                                n_ysel  = r_pa ? Y_A : Y_P;
                                n_state = S_RD;
                            end
                        end else begin
                            n_pa    = 1'b0;
                            n_exp   = r_exp >> 1;
                            n_state = S_NEXT;
                        end
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_NEXT: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (r_exp == '0) begin
                    n_state = S_EM_RD;
                end else if (r_exp[0]) begin
                    n_dst_p = 1'b0;
                    n_ysel  = Y_R;
                    n_state = S_RD;
                end else begin
                    n_dst_p = 1'b1;
                    n_ysel  = r_pa ? Y_A : Y_P;
                    n_state = S_RD;
                end
            end
            S_EM_RD: n_state = S_EM_CAP;
            S_EM_CAP: begin
                n_o_valid = 1'b1;
                n_o_row   = 3'(r_i);
                n_o_col   = 3'(r_k);
                n_o_value = 32'(w_r_eff);
                n_o_last  = w_i_end && w_k_end;
                n_o_error = 1'b0;
                n_state   = S_EM_HOLD;
            end
            S_EM_HOLD: begin
                if (i_out_ready) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EM_RD;
                        if (w_k_end) begin
                            n_k = '0;
                            n_i = r_i + IW'(1);
                        end else begin
                            n_k = r_k + IW'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_ident   <= 1'b0;
            r_pa      <= 1'b1;
            r_pow     <= 1'b0;
            r_dst_p   <= 1'b0;
            r_ysel    <= Y_B;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_exp     <= '0;
            r_dn      <= DW'(1);
            r_dm      <= DW'(1);
            r_dp      <= DW'(1);
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_ident   <= n_ident;
            r_pa      <= n_pa;
            r_pow     <= n_pow;
            r_dst_p   <= n_dst_p;
            r_ysel    <= n_ysel;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_exp     <= n_exp;
            r_dn      <= n_dn;
            r_dm      <= n_dm;
            r_dp      <= n_dp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diag    <= w_emit ? (r_i == r_k) : (r_j == r_k);
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
        r_o_error <= n_o_error;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_out_value = r_o_value;
    assign o_last      = r_o_last;
    assign o_error     = r_o_error;
endmodule
`default_nettype wire
